// ===== rtl/dcs_pkg.sv =====
// Shared constants and types of the discrete CDF sampler.
package dcs_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned PROB_BITS   = 16;

  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned PROB_W = PROB_BITS + 1;
  // The running sum of all entries cannot overflow at this width.
  localparam int unsigned SUM_W  = PROB_W + IDX_W;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [PROB_W-1:0] weight;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/dcs_if.sv =====
// Channel interfaces of the discrete CDF sampler: input items, results, configuration.
interface dcs_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [dcs_pkg::IDX_W-1:0]     entry_index;
  logic [dcs_pkg::VAL_W-1:0]     entry_value;
  logic [dcs_pkg::PROB_W-1:0]    entry_weight;
  logic [dcs_pkg::PROB_W-1:0]    draw_fraction;

  modport source (output valid, op, entry_index, entry_value, entry_weight, draw_fraction,
                  input ready);
  modport sink (input valid, op, entry_index, entry_value, entry_weight, draw_fraction,
                output ready);
endinterface

interface dcs_out_if;
  logic                      valid;
  logic                      ready;
  logic [dcs_pkg::VAL_W-1:0] picked_value;
  logic [dcs_pkg::IDX_W-1:0] picked_index;
  logic                      ran_past_end;

  modport source (output valid, picked_value, picked_index, ran_past_end, input ready);
  modport sink (input valid, picked_value, picked_index, ran_past_end, output ready);
endinterface

interface dcs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [dcs_pkg::CNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink (input valid, entry_count, output ready);
endinterface

// ===== rtl/dcs_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module dcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/dcs_walker.sv =====
// Sequencer that loads table entries and walks the table for a draw, with the result register.
module dcs_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [dcs_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [dcs_pkg::VAL_W-1:0]   entry_value_i,
  input  logic [dcs_pkg::PROB_W-1:0]  entry_weight_i,
  input  logic [dcs_pkg::PROB_W-1:0]  draw_fraction_i,
  input  logic [dcs_pkg::CNT_W-1:0]   entry_count_i,
  output dcs_pkg::mem_req_t           mem_req_o,
  input  dcs_pkg::entry_t             rd_entry_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dcs_pkg::VAL_W-1:0]   picked_value_o,
  output logic [dcs_pkg::IDX_W-1:0]   picked_index_o,
  output logic                        ran_past_end_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  localparam logic [dcs_pkg::CNT_W-1:0] CntMax = dcs_pkg::CNT_W'(dcs_pkg::MAX_ENTRIES);

  logic                        state_q, state_d;
  logic                        out_valid_q, out_valid_d;
  logic [dcs_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [dcs_pkg::IDX_W-1:0]   last_q, last_d;
  logic [dcs_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [dcs_pkg::PROB_W-1:0]  frac_q, frac_d;
  logic [dcs_pkg::VAL_W-1:0]   pval_q, pval_d;
  logic [dcs_pkg::IDX_W-1:0]   pidx_q, pidx_d;
  logic                        past_q, past_d;

  logic                        accept;
  logic                        is_draw;
  logic [dcs_pkg::CNT_W-1:0]   count_clamped;
  logic [dcs_pkg::CNT_W-1:0]   count_minus1;
  logic [dcs_pkg::SUM_W-1:0]   sum_next;
  logic                        hit;
  logic                        at_last;
  logic                        done;
  logic                        slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_draw    = (op_i == dcs_pkg::OP_DRAW);

  // Active count: zero counts as one, large counts saturate at the table size.
  always_comb begin
    if (entry_count_i == '0) begin
      count_clamped = dcs_pkg::CNT_W'(1);
    end else if (entry_count_i > CntMax) begin
      count_clamped = CntMax;
    end else begin
      count_clamped = entry_count_i;
    end
    count_minus1 = count_clamped - dcs_pkg::CNT_W'(1);
  end

  assign sum_next  = sum_q + dcs_pkg::SUM_W'(rd_entry_i.weight);
  assign hit       = dcs_pkg::SUM_W'(frac_q) <= sum_next;
  assign at_last   = (idx_q == last_q);
  assign done      = hit || at_last;
  assign slot_free = !out_valid_q || out_ready_i;

  // Loads write straight through; the walk reads one entry ahead so data arrives each cycle.
  always_comb begin
    mem_req_o.we    = accept && !is_draw;
    mem_req_o.waddr = entry_index_i;
    mem_req_o.wdata = '{value: entry_value_i, weight: entry_weight_i};
    if (state_q == ST_WALK) begin
      mem_req_o.raddr = done ? idx_q : idx_q + dcs_pkg::IDX_W'(1);
    end else begin
      mem_req_o.raddr = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    idx_d       = idx_q;
    last_d      = last_q;
    sum_d       = sum_q;
    frac_d      = frac_q;
    pval_d      = pval_q;
    pidx_d      = pidx_q;
    past_d      = past_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_draw) begin
          state_d = ST_WALK;
          idx_d   = '0;
          sum_d   = '0;
          frac_d  = draw_fraction_i;
          last_d  = count_minus1[dcs_pkg::IDX_W-1:0];
        end
      end
      ST_WALK: begin
        if (!done) begin
          idx_d = idx_q + dcs_pkg::IDX_W'(1);
          sum_d = sum_next;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          pval_d      = rd_entry_i.value;
          pidx_d      = idx_q;
          past_d      = !hit;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    sum_q  <= sum_d;
    frac_q <= frac_d;
    pval_q <= pval_d;
    pidx_q <= pidx_d;
    past_q <= past_d;
  end

  assign out_valid_o    = out_valid_q;
  assign picked_value_o = pval_q;
  assign picked_index_o = pidx_q;
  assign ran_past_end_o = past_q;

endmodule

// ===== rtl/discrete_cdf_sampler.sv =====
// Top level of the discrete CDF sampler: table memory, walk sequencer and count register.
//
// Usage. Items arrive on in_i. A load item (op = load) writes the value word and the
// Q1.16 probability of one table entry and gives no result. A draw item (op = draw) brings
// a Q1.16 fraction. The block sums entry probabilities from entry 0 upward and returns
// the first entry whose running sum reaches the fraction on out_o. If none of the active
// entries reaches it, the last active entry comes back with ran_past_end set. The number
// of active entries is written on cfg_i; a count of zero acts as one and a count above
// the table size acts as the full table.
//
// Timing. A draw that stops at entry k holds the input side while it walks entries 0 to k
// and, if the previous result is still waiting, until that result is taken. Its result is
// registered as the walk returns to idle. One entry is read from the single read port of
// the table memory and added each cycle, with the next address issued while the current
// data is checked. Input ready is low only while a draw walks the table.
//
// Reset puts the sequencer in idle, drops out_o.valid and sets the count to one. The table
// is not cleared: entries must be loaded before a draw reaches them. When the receiver
// stalls, the result waits in the output register and the block keeps taking items; a
// draw that finishes before the previous result is taken waits at its last entry.
module discrete_cdf_sampler (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcs_in_if.sink     in_i,
  dcs_cfg_if.sink    cfg_i,
  dcs_out_if.source  out_o
);

  logic [dcs_pkg::CNT_W-1:0] entry_count_q;
  dcs_pkg::mem_req_t         mem_req;
  dcs_pkg::entry_t           rd_entry;
  logic [dcs_pkg::ENTRY_W-1:0] rd_word;

  // The count register takes a transfer in any cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= dcs_pkg::CNT_W'(1);
    end else if (cfg_i.valid) begin
      entry_count_q <= cfg_i.entry_count;
    end
  end

  // One memory holds value word and probability side by side.
  dcs_ram #(
    .Width (dcs_pkg::ENTRY_W),
    .Depth (dcs_pkg::MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_word)
  );

  assign rd_entry = rd_word;

  dcs_walker u_walker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .op_i            (in_i.op),
    .entry_index_i   (in_i.entry_index),
    .entry_value_i   (in_i.entry_value),
    .entry_weight_i  (in_i.entry_weight),
    .draw_fraction_i (in_i.draw_fraction),
    .entry_count_i   (entry_count_q),
    .mem_req_o       (mem_req),
    .rd_entry_i      (rd_entry),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .picked_value_o  (out_o.picked_value),
    .picked_index_o  (out_o.picked_index),
    .ran_past_end_o  (out_o.ran_past_end)
  );

endmodule

// ===== rtl/dcs_checker.sv =====
// Port-level checks of the discrete CDF sampler and their binding to the top level.
module dcs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_op,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [dcs_pkg::VAL_W-1:0] picked_value,
  input logic [dcs_pkg::IDX_W-1:0] picked_index,
  input logic                      ran_past_end
);

  // A result waiting on a stalled receiver keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(picked_value) &&
      $stable(picked_index) && $stable(ran_past_end))
    else $error("stalled result changed");

  // A draw always walks at least one table entry before the next transfer is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op == dcs_pkg::OP_DRAW) |=> !in_ready)
    else $error("input ready right after a draw");

  // A load leaves the input ready for the next transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_op == dcs_pkg::OP_LOAD) |=> in_ready)
    else $error("input stalled after a load");

  // No result is shown while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind discrete_cdf_sampler dcs_checker u_dcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .in_op        (in_i.op),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .picked_value (out_o.picked_value),
  .picked_index (out_o.picked_index),
  .ran_past_end (out_o.ran_past_end)
);

// ===== tb/dcs_checker.sv =====
// Checker for the discrete CDF sampler: predicts each draw and compares the results.
module dcs_tb_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dcs_in_if           in_mon,
  dcs_cfg_if          cfg_mon,
  dcs_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [dcs_pkg::VAL_W-1:0] value;
    logic [dcs_pkg::IDX_W-1:0] index;
    logic                      past_end;
  } pick_t;

  logic [dcs_pkg::VAL_W-1:0]  value_tbl  [dcs_pkg::MAX_ENTRIES];
  logic [dcs_pkg::PROB_W-1:0] weight_tbl [dcs_pkg::MAX_ENTRIES];
  logic [dcs_pkg::CNT_W-1:0]  count_reg;
  pick_t                      expected_picks [$];
  int unsigned                fails;

  // Walks the active entries and returns the first whose running sum reaches
  // the fraction, or the last active entry with the past-end flag set.
  function automatic pick_t predict_pick(logic [dcs_pkg::PROB_W-1:0] fraction);
    pick_t       res;
    int unsigned active;
    logic [31:0] running;
    int unsigned k;
    active = 32'(count_reg);
    if (active == 0) active = 1;
    if (active > dcs_pkg::MAX_ENTRIES) active = dcs_pkg::MAX_ENTRIES;
    res.index    = dcs_pkg::IDX_W'(active - 1);
    res.past_end = 1'b1;
    running      = '0;
    for (k = 0; k < active; k++) begin
      running += 32'(weight_tbl[k]);
      if (32'(fraction) <= running) begin
        res.index    = dcs_pkg::IDX_W'(k);
        res.past_end = 1'b0;
        break;
      end
    end
    res.value = value_tbl[res.index];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (fails < 100) $display("%0t: mismatch: %s", $time, msg);
    fails++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want;
    if (!rst_ni) begin
      count_reg = dcs_pkg::CNT_W'(1);
      expected_picks.delete();
      fails = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) count_reg = cfg_mon.entry_count;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("result with no draw waiting, index %0d",
                                    out_mon.picked_index));
        end else begin
          want = expected_picks.pop_front();
          check_field("picked_value", out_mon.picked_value, want.value);
          check_field("picked_index", 32'(out_mon.picked_index), 32'(want.index));
          check_field("ran_past_end", 32'(out_mon.ran_past_end), 32'(want.past_end));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (dcs_pkg::op_e'(in_mon.op) == dcs_pkg::OP_LOAD) begin
          value_tbl[in_mon.entry_index]  = in_mon.entry_value;
          weight_tbl[in_mon.entry_index] = in_mon.entry_weight;
        end else begin
          expected_picks.push_back(predict_pick(in_mon.draw_fraction));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_picks.size();
  end

endmodule

// ===== tb/discrete_cdf_sampler_tb.sv =====
// Testbench top of the discrete CDF sampler: clock, reset, stimulus, watchdog and verdict.
module discrete_cdf_sampler_tb;

  // Cycles without any transfer before the run is declared hung. The slowest
  // legal stretch is the long receiver hold-off below plus one full walk.
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned ITEMS_PER_RUN = 115;
  localparam int unsigned NUM_RUNS      = 9;

  logic clk_i = 1'b0;
  logic rst_ni;

  dcs_in_if  in_if ();
  dcs_cfg_if cfg_if ();
  dcs_out_if out_if ();

  int unsigned fail_count;
  int unsigned picks_pending;

  // Idle percentages of the two sides; the receiver process reads its own.
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  // Each increment asks the receiver process for one long hold-off.
  int unsigned hold_reqs;
  int unsigned stall_cycles;

  discrete_cdf_sampler i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  dcs_tb_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .cfg_mon      (cfg_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (picks_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver owns out ready. It idles at random at the current rate, and
  // when asked it holds ready low for a long stretch so that the result
  // register stays full and the block has to stall its input.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // The watchdog restarts its count on every transfer of any channel.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offers one item and returns at the edge of its transfer. Valid is left
  // high so that a back-to-back item never drops it within the same step;
  // it is lowered only when a gap is taken or the input is stopped.
  task automatic offer_item(dcs_pkg::op_e op, logic [dcs_pkg::IDX_W-1:0] index,
                            logic [dcs_pkg::VAL_W-1:0] value,
                            logic [dcs_pkg::PROB_W-1:0] weight,
                            logic [dcs_pkg::PROB_W-1:0] fraction);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= op;
    in_if.entry_index   <= index;
    in_if.entry_value   <= value;
    in_if.entry_weight  <= weight;
    in_if.draw_fraction <= fraction;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic load_entry(logic [dcs_pkg::IDX_W-1:0] index, logic [dcs_pkg::VAL_W-1:0] value,
                            logic [dcs_pkg::PROB_W-1:0] weight);
    offer_item(dcs_pkg::OP_LOAD, index, value, weight, dcs_pkg::PROB_W'($urandom()));
  endtask

  task automatic draw_sample(logic [dcs_pkg::PROB_W-1:0] fraction);
    offer_item(dcs_pkg::OP_DRAW, dcs_pkg::IDX_W'($urandom()), $urandom(),
               dcs_pkg::PROB_W'($urandom()), fraction);
  endtask

  // Stops the input, waits until every predicted result has been taken, and
  // lets a few more cycles pass so that a trailing load has been written.
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (picks_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // The count register may only change while the block is idle.
  task automatic write_count(logic [dcs_pkg::CNT_W-1:0] count);
    settle();
    cfg_if.valid       <= 1'b1;
    cfg_if.entry_count <= count;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Weights are mostly sized so that the active entries add up to about 1.0,
  // which spreads the draws over the whole walk, with the extremes mixed in.
  function automatic logic [dcs_pkg::PROB_W-1:0] pick_weight(int unsigned active);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return dcs_pkg::PROB_W'($urandom_range(0, 2 * 65536 / active));
    if (roll < 78) return '0;
    if (roll < 86) return dcs_pkg::PROB_W'(65536);
    if (roll < 94) return dcs_pkg::PROB_W'($urandom());
    return dcs_pkg::PROB_W'(1);
  endfunction

  // Fractions are mostly uniform over 0..1.0; some lie above 1.0 and may run
  // past the end, some sit exactly on the extremes.
  function automatic logic [dcs_pkg::PROB_W-1:0] pick_fraction();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return dcs_pkg::PROB_W'($urandom_range(0, 65536));
    if (roll < 85) return dcs_pkg::PROB_W'($urandom());
    if (roll < 92) return '0;
    return dcs_pkg::PROB_W'(65536);
  endfunction

  initial begin : stimulus
    logic [dcs_pkg::CNT_W-1:0] run_count [NUM_RUNS];
    int unsigned               active;
    int unsigned               run;
    int unsigned               n;

    run_count = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd65, 7'd32, 7'd0, 7'd0};
    run_count[7] = dcs_pkg::CNT_W'($urandom_range(0, 127));
    run_count[8] = dcs_pkg::CNT_W'($urandom_range(1, 64));

    tx_idle_pct = 33;
    rx_idle_pct = 88;
    hold_reqs   = 0;
    rst_ni             <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.op           <= dcs_pkg::OP_LOAD;
    in_if.entry_index  <= '0;
    in_if.entry_value  <= '0;
    in_if.entry_weight <= '0;
    in_if.draw_fraction <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.entry_count <= dcs_pkg::CNT_W'(1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The count is one after reset, so only entry 0 is read.
    // A zero weight still meets a zero fraction; any larger fraction runs past.
    load_entry(6'd0, 32'hFFFF_FFFF, '0);
    draw_sample('0);
    draw_sample(dcs_pkg::PROB_W'(1));
    draw_sample(17'h1_FFFF);
    // A full 1.0 entry meets 1.0 exactly and misses one step above it.
    load_entry(6'd0, 32'h0000_0000, dcs_pkg::PROB_W'(65536));
    draw_sample(dcs_pkg::PROB_W'(65536));
    draw_sample(dcs_pkg::PROB_W'(65537));
    // Weights and fractions above 1.0 are taken as they are.
    load_entry(6'd63, 32'hA5A5_A5A5, 17'h1_FFFF);
    load_entry(6'd0, 32'h5A5A_5A5A, 17'h1_FFFF);
    draw_sample(17'h1_FFFF);
    // A count of zero behaves as a count of one.
    write_count(dcs_pkg::CNT_W'(0));
    draw_sample(17'h1_FFFF);
    draw_sample(17'h1_0000);
    // Three entries with zero weights in front: the sum stays flat until
    // the last one, and anything beyond it runs past the end.
    load_entry(6'd0, 32'h0000_0001, '0);
    load_entry(6'd1, 32'h1234_5678, '0);
    load_entry(6'd2, 32'h8765_4321, dcs_pkg::PROB_W'(1));
    write_count(dcs_pkg::CNT_W'(3));
    draw_sample('0);
    draw_sample(dcs_pkg::PROB_W'(1));
    draw_sample(dcs_pkg::PROB_W'(2));

    // Load every entry so that any count may be used from here on.
    for (n = 0; n < dcs_pkg::MAX_ENTRIES; n++)
      load_entry(dcs_pkg::IDX_W'(n), $urandom(), pick_weight(64));

    // Random runs. The first three idle the sender lightly and the receiver
    // heavily, the next three the other way round, and the last three not
    // at all; the first of those starts with a long receiver hold-off.
    for (run = 0; run < NUM_RUNS; run++) begin
      write_count(run_count[run]);
      active = 32'(run_count[run]);
      if (active == 0) active = 1;
      if (active > dcs_pkg::MAX_ENTRIES) active = dcs_pkg::MAX_ENTRIES;
      if (run < 3) begin
        tx_idle_pct = 33;
        rx_idle_pct = 88;
      end else if (run < 6) begin
        tx_idle_pct = 88;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (run == 6) hold_reqs <= hold_reqs + 1;
      for (n = 0; n < ITEMS_PER_RUN; n++) begin
        if ($urandom_range(99) < 35)
          load_entry(dcs_pkg::IDX_W'($urandom()), $urandom(), pick_weight(active));
        else
          draw_sample(pick_fraction());
      end
    end

    // Drain: wait for the last result, then allow one more full walk.
    settle();
    repeat (dcs_pkg::MAX_ENTRIES + 8) @(posedge clk_i);
    if (fail_count == 0 && picks_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
